// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the load/store align unit RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/slsu_pkg.sv =====
// Types, codes and constants for the SPARC load/store align unit.
// No dependencies; imported by every module of the block.
package slsu_pkg;

    localparam logic [31:0] ATOMIC_MASK     = 32'hc168_0000;
    localparam logic [31:0] ATOMIC_MATCH    = 32'hc068_0000;
    localparam logic [5:0]  OP3_LDFSR       = 6'h21;
    localparam logic [5:0]  OP3_STFSR       = 6'h25;
    localparam logic [1:0]  OP_MEM          = 2'b11;
    localparam logic [31:0] KERNEL_BASE_RST = 32'hf000_0000;

    localparam int unsigned PADDR_W = 3;
    localparam logic        REG_KERNEL_BASE = 1'b0;   // word index of the register

    localparam logic [3:0] SIZE_BYTE  = 4'd1;
    localparam logic [3:0] SIZE_HALF  = 4'd2;
    localparam logic [3:0] SIZE_WORD  = 4'd4;
    localparam logic [3:0] SIZE_DWORD = 4'd8;

    // Integer size codes in op3[1:0]
    localparam logic [1:0] SZ_WORD  = 2'd0;
    localparam logic [1:0] SZ_BYTE  = 2'd1;
    localparam logic [1:0] SZ_HALF  = 2'd2;
    localparam logic [1:0] SZ_DWORD = 2'd3;

    typedef enum logic [1:0] {
        ST_DONE        = 2'd0,
        ST_NOT_HANDLED = 2'd1,
        ST_FAULT       = 2'd2
    } t_status;

    typedef struct packed {
        logic [63:0] load_bytes;
        logic [63:0] store_value;
        logic [31:0] index_value;
        logic [31:0] base_value;
        logic [31:0] instruction;
    } t_req;

    typedef struct packed {
        logic [63:0] mem_data;
        logic [63:0] reg_data;
        logic [4:0]  dest_reg;
        logic        misaligned;
        logic [3:0]  access_size;
        logic [31:0] address;
        logic        targets_fsr;
        logic        is_float;
        logic        is_store;
        t_status     status;
    } t_resp;

endpackage

// ===== hw/rtl/slsu_cfg.sv =====
// APB register file of the load/store align unit: the kernel base register.
// Depends on slsu_pkg.
module slsu_cfg
    import slsu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [31:0]        o_kernel_base
);

    logic [31:0] r_kernel_base;
    logic        w_hit;

    // decode on the word index only; byte offset bits are ignored
    assign w_hit  = (paddr[PADDR_W-1] == REG_KERNEL_BASE);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_base <= KERNEL_BASE_RST;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_kernel_base <= pwdata;
        end
    end

    assign prdata        = w_hit ? r_kernel_base : 32'h0;
    assign o_kernel_base = r_kernel_base;

endmodule

// ===== hw/rtl/slsu_decode.sv =====
// Single-pass decode: effective address, size, kernel check and data steering.
// Depends on slsu_pkg.
module slsu_decode
    import slsu_pkg::*;
(
    input  t_req        i_req,
    input  logic [31:0] i_kernel_base,
    output t_resp       o_resp
);

    logic [31:0] w_inst;
    logic [5:0]  w_op3;
    logic [1:0]  w_sz;
    logic        w_imm, w_flt, w_store, w_sgn;
    logic        w_unhandled;
    logic [3:0]  w_size;
    logic [3:0]  w_size_m1;
    logic [31:0] w_offset;
    logic [31:0] w_addr;
    logic        w_fault;
    logic [31:0] w_word;
    logic [63:0] w_rdata;
    logic [63:0] w_mdata;

    assign w_inst  = i_req.instruction;
    assign w_op3   = w_inst[24:19];
    assign w_sz    = w_inst[20:19];
    assign w_imm   = w_inst[13];
    assign w_flt   = w_inst[24];
    assign w_store = w_inst[21];
    assign w_sgn   = w_inst[22];

    // non-memory, alternate space, ldstub/swap, quad float
    assign w_unhandled = (w_inst[31:30] != OP_MEM)
                      || (!w_imm && (w_inst[12:5] != 8'h00))
                      || ((w_inst & ATOMIC_MASK) == ATOMIC_MATCH)
                      || (w_flt && (w_sz == SZ_HALF));

    always_comb begin
        if (w_flt) begin
            w_size = (w_sz == SZ_DWORD) ? SIZE_DWORD : SIZE_WORD;
        end else begin
            case (w_sz)
                SZ_WORD:  w_size = SIZE_WORD;
                SZ_BYTE:  w_size = SIZE_BYTE;
                SZ_HALF:  w_size = SIZE_HALF;
                SZ_DWORD: w_size = SIZE_DWORD;
                default:  w_size = SIZE_WORD;
            endcase
        end
    end

    assign w_offset  = w_imm ? {{19{w_inst[12]}}, w_inst[12:0]} : i_req.index_value;
    assign w_addr    = i_req.base_value + w_offset;
    assign w_fault   = (w_addr >= i_kernel_base);
    assign w_size_m1 = w_size - 4'd1;

    // load steering: extend byte/half into the upper word
    always_comb begin
        w_word = i_req.load_bytes[31:0];
        case (w_size)
            SIZE_BYTE: w_word = {{24{w_sgn & i_req.load_bytes[7]}}, i_req.load_bytes[7:0]};
            SIZE_HALF: w_word = {{16{w_sgn & i_req.load_bytes[15]}}, i_req.load_bytes[15:0]};
            default:   w_word = i_req.load_bytes[31:0];
        endcase
        w_rdata = (w_size == SIZE_DWORD) ? i_req.load_bytes : {w_word, 32'h0};
    end

    // store steering from the rd word (or the pair for doubles)
    always_comb begin
        case (w_size)
            SIZE_BYTE: w_mdata = {56'h0, i_req.store_value[39:32]};
            SIZE_HALF: w_mdata = {48'h0, i_req.store_value[47:32]};
            SIZE_WORD: w_mdata = {32'h0, i_req.store_value[63:32]};
            default:   w_mdata = i_req.store_value;
        endcase
    end

    always_comb begin
        o_resp = '0;
        if (w_unhandled) begin
            o_resp.status = ST_NOT_HANDLED;
        end else begin
            o_resp.status      = w_fault ? ST_FAULT : ST_DONE;
            o_resp.is_store    = w_store;
            o_resp.is_float    = w_flt;
            o_resp.targets_fsr = w_flt && ((w_op3 == OP3_LDFSR) || (w_op3 == OP3_STFSR));
            o_resp.address     = w_addr;
            o_resp.access_size = w_size;
            o_resp.misaligned  = |(w_addr[3:0] & w_size_m1);
            o_resp.dest_reg    = w_inst[29:25];
            if (!w_fault) begin
                o_resp.reg_data = w_store ? 64'h0 : w_rdata;
                o_resp.mem_data = w_store ? w_mdata : 64'h0;
            end
        end
    end

endmodule

// ===== hw/rtl/sparc_load_store_align_unit.sv =====
// Top level of the SPARC load/store align unit: input stage, decode, result stage.
// Depends on slsu_pkg, slsu_cfg, slsu_decode and assert_macros.svh.
//
// Usage:
//   Slave stream: one beat per memory instruction, carrying the instruction word,
//   rs1 and rs2 values, the store register pair and the raw load bytes.
//   Master stream: one result beat per input beat, in order: status, access kind,
//   effective address, size, misalignment, rd and the steered load/store data.
//   APB port: kernel_base at byte address 0; write it only while the unit is idle.
// Pipeline: a beat accepted from the slave stream sits in the input register,
//   decode logic loads the result register from it once the result stage is
//   free, and the receiver takes the result from that register.
// Throughput: 1 beat per cycle while tready is high; the critical path is the
//   32-bit address add, then the kernel-base compare, both in the decode stage.
// Reset (synchronous, active low): both stage valids clear and kernel_base
//   returns to 0xF0000000; payload registers are not reset.
// Stall: when the receiver holds tready low, the result register keeps its beat,
//   the input stage fills once more and then tready drops on the slave side.
//   No beat is dropped or repeated.
`include "assert_macros.svh"

module sparc_load_store_align_unit
    import slsu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // slave stream
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // [31:0] instruction, [63:32] base_value, [95:64] index_value,
    // [159:96] store_value, [223:160] load_bytes
    input  logic [223:0]       i_s_axis_tdata,
    // master stream
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // [1:0] status, [2] is_store, [3] is_float, [4] targets_fsr, [36:5] address,
    // [40:37] access_size, [41] misaligned, [46:42] dest_reg, [110:47] reg_data,
    // [174:111] mem_data, [175] zero pad
    output logic [175:0]       o_m_axis_tdata,
    // APB configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic        r_s1_valid;
    t_req        r_s1_req;
    logic        r_out_valid;
    t_resp       r_out;
    logic        w_s2_ready;
    logic        w_s1_ready;
    logic [31:0] w_kernel_base;
    t_resp       w_resp;

    slsu_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_kernel_base (w_kernel_base)
    );

    // result register frees when empty or being drained this cycle
    assign w_s2_ready      = !r_out_valid || i_m_axis_tready;
    assign w_s1_ready      = !r_s1_valid || w_s2_ready;
    assign o_s_axis_tready = w_s1_ready;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && w_s1_ready) begin
            r_s1_req <= i_s_axis_tdata;
        end
    end

    slsu_decode u_decode (
        .i_req         (r_s1_req),
        .i_kernel_base (w_kernel_base),
        .o_resp        (w_resp)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_s2_ready) begin
            r_out <= w_resp;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out};

    // a beat in the input stage is never lost while the result stage is blocked
    `ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !w_s2_ready, r_s1_valid)
    // unhandled instructions carry nothing but their status
    `ASSERT_IMPLY(a_nh_clean, i_clk, i_rst_n,
        r_out_valid && (r_out.status == ST_NOT_HANDLED),
        (r_out.access_size == 4'd0) && (r_out.address == 32'h0) && !r_out.is_store)
    // a kernel-address fault moves no data
    `ASSERT_IMPLY(a_fault_nodata, i_clk, i_rst_n,
        r_out_valid && (r_out.status == ST_FAULT),
        (r_out.reg_data == 64'h0) && (r_out.mem_data == 64'h0))
    // a store never produces register data
    `ASSERT_IMPLY(a_store_noreg, i_clk, i_rst_n,
        r_out_valid && r_out.is_store, r_out.reg_data == 64'h0)

endmodule
